// File: design/consistent_hash_ring_lookup_top_macros.svh
// ----------------------------------------------------------------------------
// Consistent hash ring lookup: assertion macros
// Shared property wrappers for the ring lookup block, clocked on clock and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef CONSISTENT_HASH_RING_LOOKUP_TOP_MACROS_SVH
`define CONSISTENT_HASH_RING_LOOKUP_TOP_MACROS_SVH

// check a property on every rising clock edge outside reset
`define CHRL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// check that a condition never holds
`define CHRL_ASSERT_NEVER(label, cond, msg) \
   `CHRL_ASSERT(label, !(cond), msg)

`endif

// File: design/chrl_pkg.sv
// ----------------------------------------------------------------------------
// Consistent hash ring lookup package
// Sizes, command and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package chrl_pkg;

   // table geometry
   localparam int MAX_NODES    = 16;
   localparam int NODE_ID_BITS = 8;
   localparam int MAX_RESULTS  = 16;

   // fixed word field widths
   localparam int CMD_W    = 2;
   localparam int POS_W    = 64;
   localparam int NODE_W   = 8;
   localparam int REPL_W   = 5;
   localparam int STATUS_W = 2;
   localparam int RESULT_W = 8;

   // derived widths
   localparam int IDX_W   = $clog2(MAX_NODES);
   localparam int CNT_W   = $clog2(MAX_NODES + 1);
   localparam int SEL_W   = (CNT_W > REPL_W) ? CNT_W : REPL_W;
   localparam int ENTRY_W = POS_W + NODE_ID_BITS;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_LOOKUP = 2'd2,
      CMD_HAS    = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT_UP,
      ST_INSERT,
      ST_SHIFT_DN,
      ST_WALK,
      ST_RESP
   } state_type;

endpackage

// File: design/chrl_ifs.sv
// ----------------------------------------------------------------------------
// Consistent hash ring lookup channels
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------

// command channel
interface chrl_req_if;
   logic                               valid;
   logic                               ready;
   logic [chrl_pkg::CMD_W-1:0]         cmd;
   logic [chrl_pkg::POS_W-1:0]         position;
   logic [chrl_pkg::NODE_W-1:0]        node_id;
   logic [chrl_pkg::REPL_W-1:0]        replica_count;

   modport source (output valid, cmd, position, node_id, replica_count, input ready);
   modport sink   (input valid, cmd, position, node_id, replica_count, output ready);
endinterface

// result channel
interface chrl_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [chrl_pkg::STATUS_W-1:0]      status;
   logic [chrl_pkg::RESULT_W-1:0]      result_node;
   logic                               is_last;

   modport source (output valid, status, result_node, is_last, input ready);
   modport sink   (input valid, status, result_node, is_last, output ready);
endinterface

// File: design/consistent_hash_ring_lookup_top.sv
// ----------------------------------------------------------------------------
// Consistent hash ring lookup
// Keeps up to MAX_NODES ring entries (position, node id) sorted by position
// in a small RAM and answers add, remove, has and replica lookup commands.
// One command word is taken at a time; req ready is high only while idle.
// Every command first scans the table from entry 0, one entry per cycle, up
// to the first position at or after the requested one. Add at a new
// position then moves the entries above the insertion point up one slot,
// one per cycle, and writes the new entry; remove moves the entries above
// the hit down one slot. Lookup walks the ring from the found entry, one
// result word per cycle when the result side takes them, for
// min(replica_count, MAX_RESULTS, entry_total) words. The single RAM port
// pair sets this pace, and the result side may stall both the lookup walk
// and the status response.
// ----------------------------------------------------------------------------
`include "consistent_hash_ring_lookup_top_macros.svh"

module consistent_hash_ring_lookup_top (
   input  logic        clock,
   input  logic        reset,
   chrl_req_if.sink    req_bus,
   chrl_rsp_if.source  rsp_bus
);

   chrl_pkg::state_type  state_ff, state_in;
   chrl_pkg::cmd_type    cmd_ff, cmd_in;
   chrl_pkg::status_type status_ff, status_in;

   logic [chrl_pkg::POS_W-1:0]        pos_ff, pos_in;
   logic [chrl_pkg::NODE_ID_BITS-1:0] node_ff, node_in;
   logic [chrl_pkg::REPL_W-1:0]       repl_ff, repl_in;
   logic [chrl_pkg::CNT_W-1:0]        entry_total_ff, entry_total_in;
   logic [chrl_pkg::CNT_W-1:0]        scan_ff, scan_in;
   logic [chrl_pkg::CNT_W-1:0]        idx_ff, idx_in;
   logic [chrl_pkg::CNT_W-1:0]        sh_ff, sh_in;
   logic [chrl_pkg::IDX_W-1:0]        walk_ff, walk_in;
   logic [chrl_pkg::CNT_W-1:0]        k_ff, k_in;
   logic [chrl_pkg::CNT_W-1:0]        n_ff, n_in;

   // result word register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [chrl_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [chrl_pkg::RESULT_W-1:0]     rsp_node_ff, rsp_node_in;
   logic                              rsp_last_ff, rsp_last_in;

   // RAM ports
   logic                              wr_en;
   logic [chrl_pkg::IDX_W-1:0]        wr_addr;
   logic [chrl_pkg::ENTRY_W-1:0]      wr_data;
   logic [chrl_pkg::IDX_W-1:0]        rd_addr;
   logic [chrl_pkg::ENTRY_W-1:0]      rd_data;

   logic [chrl_pkg::POS_W-1:0]        entry_pos;
   logic [chrl_pkg::NODE_ID_BITS-1:0] entry_node;
   logic                              req_accept;
   logic                              slot_free;
   logic                              at_end;
   logic                              found;
   logic                              hit;
   logic [chrl_pkg::SEL_W-1:0]        repl_sat;
   logic [chrl_pkg::CNT_W-1:0]        walk_next;
   logic                              walk_last;

   chrl_ram #(
      .WIDTH (chrl_pkg::ENTRY_W),
      .DEPTH (chrl_pkg::MAX_NODES)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign entry_pos  = rd_data[chrl_pkg::ENTRY_W-1:chrl_pkg::NODE_ID_BITS];
   assign entry_node = rd_data[chrl_pkg::NODE_ID_BITS-1:0];

   assign req_bus.ready = (state_ff == chrl_pkg::ST_IDLE);
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign slot_free     = !rsp_valid_ff || rsp_bus.ready;

   // scan compare: one entry per cycle
   assign at_end = (scan_ff >= entry_total_ff);
   assign found  = !at_end && (entry_pos >= pos_ff);
   assign hit    = found && (entry_pos == pos_ff);

   // replica count clamped to the result limit
   assign repl_sat = (repl_ff > chrl_pkg::REPL_W'(chrl_pkg::MAX_RESULTS))
                   ? chrl_pkg::SEL_W'(chrl_pkg::MAX_RESULTS)
                   : chrl_pkg::SEL_W'(repl_ff);

   // ring walk step with wrap
   assign walk_next = (chrl_pkg::CNT_W'(walk_ff) + 1'b1 >= entry_total_ff)
                    ? '0 : chrl_pkg::CNT_W'(walk_ff) + 1'b1;
   assign walk_last = (k_ff + 1'b1 == n_ff);

   // sequencer: next state, table updates, result loads
   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      status_in      = status_ff;
      pos_in         = pos_ff;
      node_in        = node_ff;
      repl_in        = repl_ff;
      entry_total_in = entry_total_ff;
      scan_in        = scan_ff;
      idx_in         = idx_ff;
      sh_in          = sh_ff;
      walk_in        = walk_ff;
      k_in           = k_ff;
      n_in           = n_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_node_in    = rsp_node_ff;
      rsp_last_in    = rsp_last_ff;
      wr_en          = 1'b0;
      wr_addr        = '0;
      wr_data        = rd_data;
      rd_addr        = '0;

      case (state_ff)
         chrl_pkg::ST_IDLE: begin
            if (req_accept) begin
               cmd_in   = chrl_pkg::cmd_type'(req_bus.cmd);
               pos_in   = req_bus.position;
               node_in  = chrl_pkg::NODE_ID_BITS'(req_bus.node_id);
               repl_in  = req_bus.replica_count;
               scan_in  = '0;
               state_in = chrl_pkg::ST_SCAN;
            end
         end

         chrl_pkg::ST_SCAN: begin
            if (!at_end && !found) begin
               scan_in = scan_ff + 1'b1;
               rd_addr = chrl_pkg::IDX_W'(scan_ff + 1'b1);
            end else begin
               idx_in = scan_ff;
               case (cmd_ff)
                  chrl_pkg::CMD_ADD: begin
                     if (hit) begin
                        wr_en     = 1'b1;
                        wr_addr   = scan_ff[chrl_pkg::IDX_W-1:0];
                        wr_data   = {pos_ff, node_ff};
                        status_in = chrl_pkg::STATUS_OK;
                        state_in  = chrl_pkg::ST_RESP;
                     end else if (entry_total_ff >= chrl_pkg::CNT_W'(chrl_pkg::MAX_NODES)) begin
                        status_in = chrl_pkg::STATUS_FULL;
                        state_in  = chrl_pkg::ST_RESP;
                     end else if (entry_total_ff > scan_ff) begin
                        rd_addr  = chrl_pkg::IDX_W'(entry_total_ff - 1'b1);
                        sh_in    = entry_total_ff;
                        state_in = chrl_pkg::ST_SHIFT_UP;
                     end else begin
                        state_in = chrl_pkg::ST_INSERT;
                     end
                  end
                  chrl_pkg::CMD_REMOVE: begin
                     if (!hit) begin
                        status_in = chrl_pkg::STATUS_NOT_FOUND;
                        state_in  = chrl_pkg::ST_RESP;
                     end else if (scan_ff + 1'b1 < entry_total_ff) begin
                        rd_addr  = chrl_pkg::IDX_W'(scan_ff + 1'b1);
                        sh_in    = scan_ff;
                        state_in = chrl_pkg::ST_SHIFT_DN;
                     end else begin
                        entry_total_in = entry_total_ff - 1'b1;
                        status_in      = chrl_pkg::STATUS_OK;
                        state_in       = chrl_pkg::ST_RESP;
                     end
                  end
                  chrl_pkg::CMD_HAS: begin
                     status_in = hit ? chrl_pkg::STATUS_OK : chrl_pkg::STATUS_NOT_FOUND;
                     state_in  = chrl_pkg::ST_RESP;
                  end
                  default: begin
                     // lookup
                     if ((entry_total_ff == '0) || (repl_ff == '0)) begin
                        status_in = chrl_pkg::STATUS_NOT_FOUND;
                        state_in  = chrl_pkg::ST_RESP;
                     end else begin
                        n_in = (repl_sat > chrl_pkg::SEL_W'(entry_total_ff))
                             ? entry_total_ff : chrl_pkg::CNT_W'(repl_sat);
                        walk_in  = found ? scan_ff[chrl_pkg::IDX_W-1:0] : '0;
                        rd_addr  = found ? scan_ff[chrl_pkg::IDX_W-1:0] : '0;
                        k_in     = '0;
                        state_in = chrl_pkg::ST_WALK;
                     end
                  end
               endcase
            end
         end

         chrl_pkg::ST_SHIFT_UP: begin
            // entry[sh-1] moves to entry[sh]
            wr_en   = 1'b1;
            wr_addr = sh_ff[chrl_pkg::IDX_W-1:0];
            wr_data = rd_data;
            if (sh_ff - 1'b1 > idx_ff) begin
               rd_addr = chrl_pkg::IDX_W'(sh_ff - 2'd2);
               sh_in   = sh_ff - 1'b1;
            end else begin
               state_in = chrl_pkg::ST_INSERT;
            end
         end

         chrl_pkg::ST_INSERT: begin
            wr_en          = 1'b1;
            wr_addr        = idx_ff[chrl_pkg::IDX_W-1:0];
            wr_data        = {pos_ff, node_ff};
            entry_total_in = entry_total_ff + 1'b1;
            status_in      = chrl_pkg::STATUS_OK;
            state_in       = chrl_pkg::ST_RESP;
         end

         chrl_pkg::ST_SHIFT_DN: begin
            // entry[sh+1] moves to entry[sh]
            wr_en   = 1'b1;
            wr_addr = sh_ff[chrl_pkg::IDX_W-1:0];
            wr_data = rd_data;
            if (sh_ff + 2'd2 < entry_total_ff) begin
               rd_addr = chrl_pkg::IDX_W'(sh_ff + 2'd2);
               sh_in   = sh_ff + 1'b1;
            end else begin
               entry_total_in = entry_total_ff - 1'b1;
               status_in      = chrl_pkg::STATUS_OK;
               state_in       = chrl_pkg::ST_RESP;
            end
         end

         chrl_pkg::ST_WALK: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = chrl_pkg::STATUS_OK;
               rsp_node_in   = chrl_pkg::RESULT_W'(entry_node);
               rsp_last_in   = walk_last;
               walk_in       = walk_next[chrl_pkg::IDX_W-1:0];
               rd_addr       = walk_next[chrl_pkg::IDX_W-1:0];
               k_in          = k_ff + 1'b1;
               if (walk_last) begin
                  state_in = chrl_pkg::ST_IDLE;
               end
            end else begin
               rd_addr = walk_ff;
            end
         end

         chrl_pkg::ST_RESP: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_node_in   = '0;
               rsp_last_in   = 1'b1;
               state_in      = chrl_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = chrl_pkg::ST_IDLE;
         end
      endcase
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= chrl_pkg::ST_IDLE;
         entry_total_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_total_ff <= entry_total_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      status_ff     <= status_in;
      pos_ff        <= pos_in;
      node_ff       <= node_in;
      repl_ff       <= repl_in;
      scan_ff       <= scan_in;
      idx_ff        <= idx_in;
      sh_ff         <= sh_in;
      walk_ff       <= walk_in;
      k_ff          <= k_in;
      n_ff          <= n_in;
      rsp_status_ff <= rsp_status_in;
      rsp_node_ff   <= rsp_node_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.result_node = rsp_node_ff;
   assign rsp_bus.is_last     = rsp_last_ff;

   // checks
   `CHRL_ASSERT_NEVER(a_total_bound, entry_total_ff > chrl_pkg::MAX_NODES, "entry count above table size")
   `CHRL_ASSERT(a_accept_scan, req_accept |=> (state_ff == chrl_pkg::ST_SCAN), "accepted word did not start a scan")
   `CHRL_ASSERT(a_total_on_resp, (!$past(reset) && (entry_total_ff != $past(entry_total_ff))) |-> (state_ff == chrl_pkg::ST_RESP), "entry count changed outside a table update")
   `CHRL_ASSERT(a_walk_count, (state_ff == chrl_pkg::ST_WALK) |-> (k_ff < n_ff), "ring walk ran past its word count")

endmodule

// File: design/chrl_ram.sv
// ----------------------------------------------------------------------------
// Generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module chrl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
